### src/jts_pkg.sv
`timescale 1ns / 1ps

package jts_pkg;

    localparam int OFFSET_BITS_DEF = 24;
    localparam int LINE_BITS_DEF   = 16;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_STRING  = 3'd1,
        MODE_ESCAPE  = 3'd2,
        MODE_NUMBER  = 3'd3,
        MODE_KEYWORD = 3'd4,
        MODE_SIGN    = 3'd5,
        MODE_DONE    = 3'd6
    } mode_t;

    localparam logic [2:0] KIND_KEYWORD = 3'd0;
    localparam logic [2:0] KIND_STRING  = 3'd1;
    localparam logic [2:0] KIND_NUMBER  = 3'd2;
    localparam logic [2:0] KIND_SYMBOL  = 3'd3;
    localparam logic [2:0] KIND_UNDEF   = 3'd4;
    localparam logic [2:0] KIND_END     = 3'd5;
    localparam logic [2:0] KIND_ERROR   = 3'd6;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_LOWER_E   = 8'h65;
    localparam logic [7:0] CH_UPPER_E   = 8'h45;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction

    function automatic logic is_symbol(input logic [7:0] c);
        return c == CH_LBRACE || c == CH_RBRACE || c == CH_LBRACKET ||
               c == CH_RBRACKET || c == CH_COMMA || c == CH_COLON;
    endfunction

endpackage

### src/json_token_scanner.sv
`timescale 1ns / 1ps
// JSON token scanner.
// The slave channel takes one byte of JSON text per word on s_tdata; a zero
// byte ends the document. The master channel gives one token per word: the
// token kind on m_tuser, its start offset, length, first byte, row and column
// packed in m_tdata, and m_tlast on the last token caused by an input byte.
// A byte may cause no token, one token, or two (a token it closes, then the
// symbol, stray byte or end token it stands for itself).
// An accepted byte is held in the input register and decoded into the
// two-entry result register, from which its first token is shown.
// Throughput is one byte per cycle while each byte yields at most one token
// and the receiver is ready; a byte yielding two holds the next one back
// until its first token is taken; the register drains one token per cycle.
// When the receiver stalls, the result register keeps its tokens and the
// input register holds one byte, after which s_tready drops.
// Reset clears both registers, the position counters (offset 0, row 1,
// column 1) and the scan mode. After the end token every further byte gives
// another end token until reset.

module json_token_scanner
    import jts_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF,
    localparam int RAW_W      = 2 * OFFSET_BITS + 8 + 2 * LINE_BITS,
    localparam int TDATA_W    = ((RAW_W + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // char_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    // token_start, token_length, first_char, start_row, start_column
    output logic [TDATA_W-1:0] m_tdata,
    output logic [2:0]         m_tuser,   // token_kind
    output logic               m_tlast    // last_result
);

    logic                   in_valid_reg, in_valid_next;
    logic [7:0]             in_byte_reg;
    logic                   core_ready;
    logic [OFFSET_BITS-1:0] tok_start;
    logic [OFFSET_BITS-1:0] tok_length;
    logic [7:0]             tok_first;
    logic [LINE_BITS-1:0]   tok_row;
    logic [LINE_BITS-1:0]   tok_col;

    assign s_tready = !in_valid_reg || core_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    jts_core #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (in_valid_reg),
        .in_ready   (core_ready),
        .in_byte    (in_byte_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (m_tuser),
        .out_start  (tok_start),
        .out_length (tok_length),
        .out_first  (tok_first),
        .out_row    (tok_row),
        .out_col    (tok_col),
        .out_last   (m_tlast)
    );

    assign m_tdata = TDATA_W'({tok_col, tok_row, tok_first, tok_length, tok_start});

endmodule

### src/jts_core.sv
`timescale 1ns / 1ps

module jts_core
    import jts_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             in_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             out_kind,
    output logic [OFFSET_BITS-1:0] out_start,
    output logic [OFFSET_BITS-1:0] out_length,
    output logic [7:0]             out_first,
    output logic [LINE_BITS-1:0]   out_row,
    output logic [LINE_BITS-1:0]   out_col,
    output logic                   out_last
);

    typedef struct packed {
        logic [2:0]             kind;
        logic [OFFSET_BITS-1:0] start;
        logic [OFFSET_BITS-1:0] length;
        logic [7:0]             first;
        logic [LINE_BITS-1:0]   row;
        logic [LINE_BITS-1:0]   col;
    } tok_t;

    localparam logic [OFFSET_BITS-1:0] OFF_ONE  = OFFSET_BITS'(1);
    localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);

    // Scanner state.
    mode_t                  mode_reg,  mode_next;
    logic [OFFSET_BITS-1:0] off_reg,   off_next;
    logic [LINE_BITS-1:0]   line_reg,  line_next;
    logic [LINE_BITS-1:0]   col_reg,   col_next;
    logic [OFFSET_BITS-1:0] tbeg_reg,  tbeg_next;
    logic [LINE_BITS-1:0]   trow_reg,  trow_next;
    logic [LINE_BITS-1:0]   tcol_reg,  tcol_next;
    logic [7:0]             held_reg,  held_next;

    // Result pair: slot 0 is shown on the output, slot 1 waits behind it.
    logic [1:0] cnt_reg,   cnt_next;
    tok_t       slot0_reg, slot0_next;
    tok_t       slot1_reg, slot1_next;

    logic                   fire;
    logic                   pop;
    logic [7:0]             c;
    logic [OFFSET_BITS-1:0] off_inc;
    logic [LINE_BITS-1:0]   col_inc;
    logic [LINE_BITS-1:0]   line_inc;
    tok_t                   pend_tok;
    tok_t                   end_tok;
    tok_t                   pre_tok;
    tok_t                   sec_tok;
    logic                   pre_emit;
    logic                   sec_emit;
    logic                   go_idle;
    logic                   do_consume;
    logic [1:0]             n_res;

    assign c        = in_byte;
    assign off_inc  = (off_reg == '1) ? off_reg : off_reg + OFF_ONE;
    assign col_inc  = (col_reg == '1) ? col_reg : col_reg + LINE_ONE;
    assign line_inc = (line_reg == '1) ? line_reg : line_reg + LINE_ONE;

    assign pend_tok = '{kind: KIND_STRING, start: tbeg_reg, length: off_reg - tbeg_reg,
                        first: held_reg, row: trow_reg, col: tcol_reg};
    assign end_tok  = '{kind: KIND_END, start: off_reg, length: '0, first: 8'h00,
                        row: line_reg, col: col_reg};

    assign in_ready  = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);
    assign fire      = in_valid && in_ready;
    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && out_ready;

    // Per-byte scan decision. A byte that ends a pending token may also start
    // or end another, so up to two results come out of one byte.
    always_comb begin
        mode_next  = mode_reg;
        tbeg_next  = tbeg_reg;
        trow_next  = trow_reg;
        tcol_next  = tcol_reg;
        held_next  = held_reg;
        pre_emit   = 1'b0;
        pre_tok    = pend_tok;
        sec_emit   = 1'b0;
        sec_tok    = end_tok;
        go_idle    = 1'b0;
        do_consume = 1'b1;

        unique case (mode_reg)
            MODE_STRING, MODE_ESCAPE: begin
                if (c == CH_NUL) begin
                    pre_emit      = 1'b1;
                    pre_tok.kind  = KIND_ERROR;
                    sec_emit      = 1'b1;
                    mode_next     = MODE_DONE;
                    do_consume    = 1'b0;
                end else if (mode_reg == MODE_STRING && c == CH_QUOTE) begin
                    pre_emit     = 1'b1;
                    pre_tok.kind = KIND_STRING;
                    mode_next    = MODE_IDLE;
                end else begin
                    if (off_reg == tbeg_reg) begin
                        held_next = c;
                    end
                    mode_next = (mode_reg == MODE_STRING && c == CH_BACKSLASH) ?
                                MODE_ESCAPE : MODE_STRING;
                end
            end
            MODE_NUMBER: begin
                if (!(is_digit(c) || c == CH_DOT || c == CH_LOWER_E || c == CH_UPPER_E)) begin
                    pre_emit     = 1'b1;
                    pre_tok.kind = KIND_NUMBER;
                    go_idle      = 1'b1;
                end
            end
            MODE_KEYWORD: begin
                if (!(is_alpha(c) || is_digit(c))) begin
                    pre_emit     = 1'b1;
                    pre_tok.kind = KIND_KEYWORD;
                    go_idle      = 1'b1;
                end
            end
            MODE_SIGN: begin
                if (is_digit(c)) begin
                    mode_next = MODE_NUMBER;
                end else begin
                    pre_emit       = 1'b1;
                    pre_tok.kind   = KIND_UNDEF;
                    pre_tok.length = OFF_ONE;
                    go_idle        = 1'b1;
                end
            end
            MODE_IDLE: begin
                go_idle = 1'b1;
            end
            MODE_DONE: begin
                pre_emit   = 1'b1;
                pre_tok    = end_tok;
                do_consume = 1'b0;
            end
            default: begin
                pre_emit   = 1'b1;
                pre_tok    = end_tok;
                do_consume = 1'b0;
            end
        endcase

        if (go_idle) begin
            mode_next = MODE_IDLE;
            sec_tok   = '{kind: KIND_SYMBOL, start: off_reg, length: OFF_ONE, first: c,
                          row: line_reg, col: col_reg};
            priority if (c == CH_NUL) begin
                sec_emit   = 1'b1;
                sec_tok    = end_tok;
                mode_next  = MODE_DONE;
                do_consume = 1'b0;
            end else if (c == CH_QUOTE) begin
                mode_next = MODE_STRING;
                tbeg_next = off_inc;
                trow_next = line_reg;
                tcol_next = col_inc;
                held_next = 8'h00;
            end else if (is_digit(c) || c == CH_PLUS || c == CH_MINUS || is_alpha(c)) begin
                mode_next = is_digit(c) ? MODE_NUMBER :
                            (is_alpha(c) ? MODE_KEYWORD : MODE_SIGN);
                tbeg_next = off_reg;
                trow_next = line_reg;
                tcol_next = col_reg;
                held_next = c;
            end else if (is_symbol(c)) begin
                sec_emit = 1'b1;
            end else if (!is_space(c)) begin
                sec_emit     = 1'b1;
                sec_tok.kind = KIND_UNDEF;
            end else begin
                sec_emit = 1'b0;
            end
        end

        n_res = {1'b0, pre_emit} + {1'b0, sec_emit};
    end

    always_comb begin
        off_next  = off_reg;
        line_next = line_reg;
        col_next  = col_reg;
        if (do_consume) begin
            off_next = off_inc;
            if (c == CH_NEWLINE) begin
                line_next = line_inc;
                col_next  = LINE_ONE;
            end else begin
                col_next = col_inc;
            end
        end
    end

    // The pair is always empty after this edge when a byte is taken, so the
    // new results load from slot 0 upward.
    always_comb begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (fire) begin
            cnt_next   = n_res;
            slot0_next = pre_emit ? pre_tok : sec_tok;
            slot1_next = sec_tok;
        end else if (pop) begin
            cnt_next   = cnt_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            off_reg  <= '0;
            line_reg <= LINE_ONE;
            col_reg  <= LINE_ONE;
            tbeg_reg <= '0;
            trow_reg <= LINE_ONE;
            tcol_reg <= LINE_ONE;
            held_reg <= 8'h00;
            cnt_reg  <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (fire) begin
                mode_reg <= mode_next;
                off_reg  <= off_next;
                line_reg <= line_next;
                col_reg  <= col_next;
                tbeg_reg <= tbeg_next;
                trow_reg <= trow_next;
                tcol_reg <= tcol_next;
                held_reg <= held_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign out_kind   = slot0_reg.kind;
    assign out_start  = slot0_reg.start;
    assign out_length = slot0_reg.length;
    assign out_first  = slot0_reg.first;
    assign out_row    = slot0_reg.row;
    assign out_col    = slot0_reg.col;
    assign out_last   = (cnt_reg == 2'd1);

endmodule

### src/jts_checker.sv
`timescale 1ns / 1ps

module jts_checker
    import jts_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF,
    localparam int RAW_W      = 2 * OFFSET_BITS + 8 + 2 * LINE_BITS,
    localparam int TDATA_W    = ((RAW_W + 7) / 8) * 8
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic [2:0]         m_tuser,
    input logic               m_tlast
);

    logic                   seen_end_reg;
    logic [OFFSET_BITS-1:0] len;
    logic [7:0]             first;

    assign len   = m_tdata[2*OFFSET_BITS-1:OFFSET_BITS];
    assign first = m_tdata[2*OFFSET_BITS+7:2*OFFSET_BITS];

    // Remembers that the end of the document has been delivered.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_end_reg <= 1'b0;
        end else if (m_tvalid && m_tready && m_tuser == KIND_END) begin
            seen_end_reg <= 1'b1;
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("token changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("token shown right after reset");

    a_end_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_END |-> len == '0 && first == 8'h00 && m_tlast)
        else $error("malformed end token");

    a_one_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_SYMBOL || m_tuser == KIND_UNDEF)
        |-> len == OFFSET_BITS'(1))
        else $error("symbol or stray token not one byte long");

    a_end_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_end_reg && m_tvalid |-> m_tuser == KIND_END)
        else $error("token other than end after end of document");

endmodule

bind json_token_scanner jts_checker #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS)
) u_jts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

### sim/json_token_scanner_test.sv
`timescale 1ns / 1ps

module json_token_scanner_test;
    import jts_pkg::*;

    localparam int OFF_W       = 24;
    localparam int ROW_W       = 16;
    localparam int DATA_W      = 88;
    localparam int DOC_BYTES   = 1300;
    localparam int QUIET_LIMIT = 1000;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic [7:0]        s_tdata  = 8'h00;
    logic              m_tready = 1'b0;
    wire               s_tready;
    wire               m_tvalid;
    wire  [DATA_W-1:0] m_tdata;
    wire  [2:0]        m_tuser;
    wire               m_tlast;

    json_token_scanner uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    typedef struct {
        logic [2:0]       kind;
        logic [OFF_W-1:0] start;
        logic [OFF_W-1:0] length;
        logic [7:0]       first;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        logic             last;
    } token_t;

    token_t expected_tokens[$];

    // Scanner state as the testbench tracks it.
    mode_t            scan_st    = MODE_IDLE;
    logic [OFF_W-1:0] pos_offset = '0;
    logic [ROW_W-1:0] pos_line   = ROW_W'(1);
    logic [ROW_W-1:0] pos_col    = ROW_W'(1);
    logic [OFF_W-1:0] tok_begin  = '0;
    logic [ROW_W-1:0] tok_line   = ROW_W'(1);
    logic [ROW_W-1:0] tok_col    = ROW_W'(1);
    logic [7:0]       tok_first  = 8'h00;

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int bytes_sent     = 0;
    int burst_left     = 0;
    int stall_left     = 0;
    int stall_style    = 0;
    int style_left     = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic bit ws_char(input logic [7:0] c);
        return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit digit_char(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit letter_char(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit symbol_char(input logic [7:0] c);
        return c == CH_LBRACE || c == CH_RBRACE || c == CH_LBRACKET ||
               c == CH_RBRACKET || c == CH_COMMA || c == CH_COLON;
    endfunction

    function automatic logic [OFF_W-1:0] bump_offset(input logic [OFF_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [ROW_W-1:0] bump_line(input logic [ROW_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function void push_token(input logic [2:0] kind, input logic [OFF_W-1:0] start,
                             input logic [OFF_W-1:0] length, input logic [7:0] first,
                             input logic [ROW_W-1:0] row, input logic [ROW_W-1:0] col);
        token_t t;
        t.kind   = kind;
        t.start  = start;
        t.length = length;
        t.first  = first;
        t.row    = row;
        t.col    = col;
        t.last   = 1'b0;
        expected_tokens.push_back(t);
    endfunction

    function void push_open_token(input logic [2:0] kind);
        push_token(kind, tok_begin, pos_offset - tok_begin, tok_first, tok_line, tok_col);
    endfunction

    function void push_end_token();
        push_token(KIND_END, pos_offset, '0, 8'h00, pos_line, pos_col);
        scan_st = MODE_DONE;
    endfunction

    function void advance_position(input logic [7:0] c);
        pos_offset = bump_offset(pos_offset);
        if (c == CH_NEWLINE) begin
            pos_line = bump_line(pos_line);
            pos_col  = ROW_W'(1);
        end else begin
            pos_col = bump_line(pos_col);
        end
    endfunction

    function void open_token(input mode_t m, input logic [7:0] c);
        scan_st   = m;
        tok_begin = pos_offset;
        tok_line  = pos_line;
        tok_col   = pos_col;
        tok_first = c;
    endfunction

    // A byte seen with no token in progress.
    function void scan_fresh_byte(input logic [7:0] c);
        scan_st = MODE_IDLE;
        if (c == CH_NUL) begin
            push_end_token();
        end else begin
            if (c == CH_QUOTE) begin
                // The string token starts on the byte after the quote.
                scan_st   = MODE_STRING;
                tok_begin = bump_offset(pos_offset);
                tok_line  = pos_line;
                tok_col   = bump_line(pos_col);
                tok_first = 8'h00;
            end else if (digit_char(c)) begin
                open_token(MODE_NUMBER, c);
            end else if (c == CH_PLUS || c == CH_MINUS) begin
                open_token(MODE_SIGN, c);
            end else if (letter_char(c)) begin
                open_token(MODE_KEYWORD, c);
            end else if (symbol_char(c)) begin
                push_token(KIND_SYMBOL, pos_offset, OFF_W'(1), c, pos_line, pos_col);
            end else if (!ws_char(c)) begin
                push_token(KIND_UNDEF, pos_offset, OFF_W'(1), c, pos_line, pos_col);
            end
            advance_position(c);
        end
    endfunction

    function void predict_tokens(input logic [7:0] c);
        int count_before;
        count_before = expected_tokens.size();
        case (scan_st)
            MODE_STRING, MODE_ESCAPE: begin
                if (c == CH_NUL) begin
                    push_open_token(KIND_ERROR);
                    push_end_token();
                end else begin
                    if (scan_st == MODE_STRING && c == CH_QUOTE) begin
                        push_open_token(KIND_STRING);
                        scan_st = MODE_IDLE;
                    end else begin
                        if (pos_offset == tok_begin)
                            tok_first = c;
                        scan_st = (scan_st == MODE_STRING && c == CH_BACKSLASH) ?
                                  MODE_ESCAPE : MODE_STRING;
                    end
                    advance_position(c);
                end
            end
            MODE_NUMBER: begin
                if (digit_char(c) || c == CH_DOT || c == CH_LOWER_E || c == CH_UPPER_E) begin
                    advance_position(c);
                end else begin
                    push_open_token(KIND_NUMBER);
                    scan_fresh_byte(c);
                end
            end
            MODE_KEYWORD: begin
                if (letter_char(c) || digit_char(c)) begin
                    advance_position(c);
                end else begin
                    push_open_token(KIND_KEYWORD);
                    scan_fresh_byte(c);
                end
            end
            MODE_SIGN: begin
                if (digit_char(c)) begin
                    scan_st = MODE_NUMBER;
                    advance_position(c);
                end else begin
                    push_token(KIND_UNDEF, tok_begin, OFF_W'(1), tok_first, tok_line, tok_col);
                    scan_fresh_byte(c);
                end
            end
            MODE_IDLE: scan_fresh_byte(c);
            default:   push_end_token();
        endcase
        if (expected_tokens.size() > count_before)
            expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    endfunction

    function void note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endfunction

    function void check_token();
        token_t want;
        if (expected_tokens.size() == 0) begin
            note_failure($sformatf("unexpected token: kind %0d tdata %h last %b",
                                   m_tuser, m_tdata, m_tlast));
        end else begin
            want = expected_tokens.pop_front();
            if (m_tuser !== want.kind || m_tdata[23:0] !== want.start ||
                m_tdata[47:24] !== want.length || m_tdata[55:48] !== want.first ||
                m_tdata[71:56] !== want.row || m_tdata[87:72] !== want.col ||
                m_tlast !== want.last) begin
                note_failure($sformatf({"token mismatch: expected kind %0d start %0d len %0d",
                    " first %h row %0d col %0d last %b; got kind %0d start %0d len %0d",
                    " first %h row %0d col %0d last %b"},
                    want.kind, want.start, want.length, want.first, want.row, want.col,
                    want.last, m_tuser, m_tdata[23:0], m_tdata[47:24], m_tdata[55:48],
                    m_tdata[71:56], m_tdata[87:72], m_tlast));
            end
        end
    endfunction

    // Predict on the input word before checking the output word of the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                predict_tokens(s_tdata);
            if (m_tvalid && m_tready)
                check_token();
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
        end
    end

    // Receiver: switches between no stalls, scattered stalls and long stalls.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            if (style_left == 0) begin
                stall_style = $urandom_range(0, 2);
                style_left  = $urandom_range(20, 200);
            end else begin
                style_left--;
            end
            case (stall_style)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: begin
                    if ($urandom_range(0, 5) == 0) begin
                        stall_left = $urandom_range(1, 10);
                        m_tready <= 1'b0;
                    end else begin
                        m_tready <= 1'b1;
                    end
                end
            endcase
        end
    end

    initial begin
        do @(posedge aclk); while (quiet_cycles < QUIET_LIMIT);
        $display("no word moved for %0d cycles", QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // s_tvalid stays high after a word so that back-to-back words need no toggle.
    task automatic send_byte(input logic [7:0] c);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_blank();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0:       c = CH_NEWLINE;
            1:       c = 8'd9;
            2:       c = 8'd13;
            default: c = CH_SPACE;
        endcase
        send_byte(c);
    endtask

    task automatic test_directed_tokens();
        // Escape as first string byte, a lone sign, an exponent sign that splits a
        // number, keyword with a digit, an empty string and stray bytes.
        send_text("{\"\\q\":+-1e-5,t3 x\n[\"\"]");
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(CH_DOT);
    endtask

    task automatic test_random_documents(input int target);
        string      symbols;
        string      num_tail;
        string      words[3];
        int         goal;
        int         n;
        logic [7:0] c;
        symbols  = "{}[],:";
        num_tail = "0123456789.eE-";
        words    = '{"true", "false", "null"};
        goal     = bytes_sent + target;
        while (bytes_sent < goal) begin
            case ($urandom_range(0, 9))
                0, 1: send_byte(symbols[$urandom_range(0, 5)]);
                2, 3: begin
                    send_byte(CH_QUOTE);
                    n = $urandom_range(0, 8);
                    repeat (n) begin
                        c = 8'($urandom_range(1, 255));
                        if (c == CH_QUOTE)
                            c = 8'h27;
                        if ($urandom_range(0, 5) == 0 || c == CH_BACKSLASH) begin
                            send_byte(CH_BACKSLASH);
                            c = 8'($urandom_range(1, 255));
                        end
                        send_byte(c);
                    end
                    // Now and then the string runs on into the following tokens.
                    if ($urandom_range(0, 15) != 0)
                        send_byte(CH_QUOTE);
                end
                4, 5: begin
                    if ($urandom_range(0, 2) == 0)
                        send_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                    send_byte(8'("0" + $urandom_range(0, 9)));
                    n = $urandom_range(0, 6);
                    repeat (n) begin
                        c = num_tail[$urandom_range(0, 13)];
                        send_byte(c);
                    end
                end
                6: begin
                    if ($urandom_range(0, 2) == 0) begin
                        send_text(words[$urandom_range(0, 2)]);
                    end else begin
                        send_byte(8'($urandom_range(0, 1) ? "A" + $urandom_range(0, 25) :
                                                            "a" + $urandom_range(0, 25)));
                        n = $urandom_range(0, 6);
                        repeat (n) begin
                            case ($urandom_range(0, 2))
                                0:       c = 8'("0" + $urandom_range(0, 9));
                                1:       c = 8'("A" + $urandom_range(0, 25));
                                default: c = 8'("a" + $urandom_range(0, 25));
                            endcase
                            send_byte(c);
                        end
                    end
                end
                7: begin
                    n = $urandom_range(1, 3);
                    repeat (n) send_blank();
                end
                8: send_byte(8'($urandom_range(1, 255)));
                default: begin
                    send_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                    send_byte(8'($urandom_range(1, 255)));
                end
            endcase
            if ($urandom_range(0, 2) == 0)
                send_blank();
        end
    endtask

    task automatic test_sender_pause();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_tokens.size() != 0);
        burst_left = 0;
    endtask

    task automatic test_end_of_document();
        // Only one document end per run, so the state it hits is drawn at random.
        case ($urandom_range(0, 5))
            0:       send_text("ab");
            1:       send_text("12.5");
            2:       send_text("-");
            3:       send_text("\"xy");
            4:       send_text("\"x\\");
            default: send_text(" ");
        endcase
        send_byte(CH_NUL);
        repeat (20) send_byte(8'($urandom_range(0, 255)));
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_tokens();
        test_random_documents(DOC_BYTES / 2);
        test_sender_pause();
        test_random_documents(DOC_BYTES / 2);
        test_end_of_document();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_tokens.size() != 0);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && expected_tokens.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d tokens still expected",
                     mismatch_count, expected_tokens.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
